// ===== sv/harris_corner_response_defines.svh =====
// assertion macros, sampled on clk_i and switched off during reset
`ifndef HARRIS_CORNER_RESPONSE_DEFINES_SVH
`define HARRIS_CORNER_RESPONSE_DEFINES_SVH

// same-cycle implication
`define HCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hcr_pkg.sv =====
`timescale 1ns / 1ps

package hcr_pkg;

  localparam int unsigned MAX_WIDTH_DEFAULT  = 128;
  localparam int unsigned MAX_HEIGHT_DEFAULT = 128;
  localparam int unsigned GRAD_BITS_DEFAULT  = 12;

  localparam int unsigned POS_W      = 7;
  localparam int unsigned IN_GRAD_W  = 12;
  localparam int unsigned GRAD_MAX_W = 16;
  localparam int unsigned DIM_W      = 8;
  localparam int unsigned K_W        = 16;
  localparam int unsigned RESP_W     = 61;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 8'd128;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 8'd128;
  localparam logic [K_W-1:0]   HARRIS_K_RST     = 16'd2621;

  localparam logic KIND_EVENT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_HARRIS_K     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [K_W-1:0]   harris_k;
  } hcr_cfg_t;

  // classified transaction as it sits in the queue
  typedef struct packed {
    logic                         is_event;
    logic                         in_store;
    logic [POS_W-1:0]             pos_x;
    logic [POS_W-1:0]             pos_y;
    logic signed [GRAD_MAX_W-1:0] gx;
    logic signed [GRAD_MAX_W-1:0] gy;
  } hcr_item_t;

endpackage

// ===== sv/harris_corner_response.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                    payload
// item      in   start, busy                  kind_i pos_x_i pos_y_i grad_x_i grad_y_i
// result    out  resp_valid_o, one cycle      response_o out_x_o out_y_o
// config    in   cfg_we_i                     cfg_index_i cfg_wdata_i
//
// a gradient write holds the single store port while it is written
// an event holds it for nine reads, one a cycle; the sums then go to the response stage
// after reset busy stays high while every store address is cleared; config writes
// are taken meanwhile
// a four-deep queue takes transactions while the back end works; busy when it fills
// results cannot be held off by the receiver

`include "harris_corner_response_defines.svh"

module harris_corner_response #(
  parameter int unsigned MAX_WIDTH  = hcr_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned MAX_HEIGHT = hcr_pkg::MAX_HEIGHT_DEFAULT,
  parameter int unsigned GRAD_BITS  = hcr_pkg::GRAD_BITS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind_i,
  input  logic [hcr_pkg::POS_W-1:0]          pos_x_i,
  input  logic [hcr_pkg::POS_W-1:0]          pos_y_i,
  input  logic signed [hcr_pkg::IN_GRAD_W-1:0] grad_x_i,
  input  logic signed [hcr_pkg::IN_GRAD_W-1:0] grad_y_i,
  input  logic                               cfg_we_i,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hcr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                               resp_valid_o,
  output logic signed [hcr_pkg::RESP_W-1:0]  response_o,
  output logic [hcr_pkg::POS_W-1:0]          out_x_o,
  output logic [hcr_pkg::POS_W-1:0]          out_y_o
);
  import hcr_pkg::*;

  localparam int unsigned SW = 2 * GRAD_BITS + 2;

  hcr_cfg_t           cfg;
  hcr_item_t          q_item;
  hcr_item_t          q_head;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic               clearing;
  logic               sum_valid;
  logic               sum_ready;
  logic [SW-1:0]      sum_sxx;
  logic [SW-1:0]      sum_syy;
  logic signed [SW:0] sum_sxy;
  logic [POS_W-1:0]   sum_x;
  logic [POS_W-1:0]   sum_y;

  hcr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .GRAD_BITS  (GRAD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .grad_x_i    (grad_x_i),
    .grad_y_i    (grad_y_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .push_o      (q_push),
    .item_o      (q_item),
    .cfg_o       (cfg)
  );

  hcr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_head),
    .empty_o     (q_empty)
  );

  hcr_gather #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .GRAD_BITS  (GRAD_BITS)
  ) u_gather (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sxx_o       (sum_sxx),
    .syy_o       (sum_syy),
    .sxy_o       (sum_sxy),
    .ev_x_o      (sum_x),
    .ev_y_o      (sum_y)
  );

  hcr_resp #(
    .GRAD_BITS (GRAD_BITS)
  ) u_resp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .harris_k_i   (cfg.harris_k),
    .sum_valid_i  (sum_valid),
    .sum_ready_o  (sum_ready),
    .sxx_i        (sum_sxx),
    .syy_i        (sum_syy),
    .sxy_i        (sum_sxy),
    .ev_x_i       (sum_x),
    .ev_y_i       (sum_y),
    .resp_valid_o (resp_valid_o),
    .response_o   (response_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o)
  );

  `HCR_ASSERT_NOW(a_busy_while_clearing, clearing, busy && q_empty, "transaction during store clear")
  `HCR_ASSERT_NEXT(a_single_strobe, resp_valid_o, !resp_valid_o, "result strobe longer than one cycle")
  `HCR_ASSERT_NEXT(a_sums_held, sum_valid && !sum_ready, sum_valid && $stable(sum_sxx) && $stable(sum_x), "sums changed while waiting")

endmodule

// ===== sv/hcr_front.sv =====
`timescale 1ns / 1ps

module hcr_front #(
  parameter int unsigned MAX_WIDTH  = hcr_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned MAX_HEIGHT = hcr_pkg::MAX_HEIGHT_DEFAULT,
  parameter int unsigned GRAD_BITS  = hcr_pkg::GRAD_BITS_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   kind_i,
  input  logic [hcr_pkg::POS_W-1:0]              pos_x_i,
  input  logic [hcr_pkg::POS_W-1:0]              pos_y_i,
  input  logic signed [hcr_pkg::IN_GRAD_W-1:0]   grad_x_i,
  input  logic signed [hcr_pkg::IN_GRAD_W-1:0]   grad_y_i,
  input  logic                                   cfg_we_i,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [hcr_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                                   q_full_i,
  input  logic                                   clearing_i,
  output logic                                   push_o,
  output hcr_pkg::hcr_item_t                     item_o,
  output hcr_pkg::hcr_cfg_t                      cfg_o
);
  import hcr_pkg::*;

  localparam int unsigned GRAD_EXT_W = GRAD_MAX_W + 1;
  localparam logic signed [GRAD_EXT_W-1:0] GradHi = GRAD_EXT_W'(2 ** (GRAD_BITS - 1) - 1);
  localparam logic signed [GRAD_EXT_W-1:0] GradLo = ~GradHi;

  hcr_cfg_t cfg_q;

  function automatic logic signed [GRAD_MAX_W-1:0] sat_grad(
    input logic signed [IN_GRAD_W-1:0] g
  );
    logic signed [GRAD_EXT_W-1:0] e;
    logic signed [GRAD_EXT_W-1:0] s;
    e = GRAD_EXT_W'(g);
    if (e > GradHi) begin
      s = GradHi;
    end else if (e < GradLo) begin
      s = GradLo;
    end else begin
      s = e;
    end
    return s[GRAD_MAX_W-1:0];
  endfunction

  assign busy   = q_full_i | clearing_i;
  assign push_o = start & ~busy;

  always_comb begin
    item_o.is_event = (kind_i == KIND_EVENT);
    item_o.in_store = (32'(pos_x_i) < 32'(MAX_WIDTH)) && (32'(pos_y_i) < 32'(MAX_HEIGHT));
    item_o.pos_x    = pos_x_i;
    item_o.pos_y    = pos_y_i;
    item_o.gx       = sat_grad(grad_x_i);
    item_o.gy       = sat_grad(grad_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= FRAME_WIDTH_RST;
      cfg_q.frame_height <= FRAME_HEIGHT_RST;
      cfg_q.harris_k     <= HARRIS_K_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_wdata_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_wdata_i[DIM_W-1:0];
        CFG_HARRIS_K:     cfg_q.harris_k     <= cfg_wdata_i[K_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/hcr_fifo.sv =====
`timescale 1ns / 1ps

module hcr_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hcr_pkg::hcr_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output hcr_pkg::hcr_item_t pop_data_o,
  output logic               empty_o
);
  import hcr_pkg::*;

  hcr_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== sv/hcr_gather.sv =====
`timescale 1ns / 1ps

module hcr_gather #(
  parameter int unsigned MAX_WIDTH  = hcr_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned MAX_HEIGHT = hcr_pkg::MAX_HEIGHT_DEFAULT,
  parameter int unsigned GRAD_BITS  = hcr_pkg::GRAD_BITS_DEFAULT,
  localparam int unsigned SW        = 2 * GRAD_BITS + 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hcr_pkg::hcr_cfg_t           cfg_i,
  input  logic                        q_empty_i,
  input  hcr_pkg::hcr_item_t          q_head_i,
  output logic                        q_pop_o,
  output logic                        clearing_o,
  output logic                        sum_valid_o,
  input  logic                        sum_ready_i,
  output logic [SW-1:0]               sxx_o,
  output logic [SW-1:0]               syy_o,
  output logic signed [SW:0]          sxy_o,
  output logic [hcr_pkg::POS_W-1:0]   ev_x_o,
  output logic [hcr_pkg::POS_W-1:0]   ev_y_o
);
  import hcr_pkg::*;

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned GW    = GRAD_BITS;
  localparam int unsigned NW    = POS_W + 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_HAND
  } state_e;

  state_e           state_q;
  logic [AW-1:0]    clr_addr_q;
  logic [1:0]       col_q;
  logic [1:0]       row_q;
  logic [POS_W-1:0] ev_x_q;
  logic [POS_W-1:0] ev_y_q;
  logic             nb_ok_q;

  logic [2*GW-1:0]  grad_store_q [DEPTH];
  logic [2*GW-1:0]  rdata_q;

  logic [SW-1:0]      sxx_q;
  logic [SW-1:0]      syy_q;
  logic signed [SW:0] sxy_q;

  logic              pop_write;
  logic              pop_event;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [2*GW-1:0]   mem_wdata;
  logic [NW-1:0]     nx;
  logic [NW-1:0]     ny;
  logic [DIM_W-1:0]  w_cap;
  logic [DIM_W-1:0]  h_cap;
  logic              nb_in_frame;

  logic signed [GW-1:0]   gx;
  logic signed [GW-1:0]   gy;
  logic signed [2*GW-1:0] pxx;
  logic signed [2*GW-1:0] pyy;
  logic signed [2*GW-1:0] pxy;

  assign q_pop_o   = (state_q == ST_IDLE) & ~q_empty_i;
  assign pop_write = q_pop_o & ~q_head_i.is_event;
  assign pop_event = q_pop_o & q_head_i.is_event;

  // active frame clipped to the store
  assign w_cap = (32'(cfg_i.frame_width) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                          : cfg_i.frame_width;
  assign h_cap = (32'(cfg_i.frame_height) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                            : cfg_i.frame_height;

  // neighbour coordinates, minus one wraps high and falls outside
  assign nx = NW'(ev_x_q) + NW'(col_q) - NW'(1);
  assign ny = NW'(ev_y_q) + NW'(row_q) - NW'(1);
  assign nb_in_frame = (nx < NW'(w_cap)) && (ny < NW'(h_cap));

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {YW'(ny), XW'(nx)};
    mem_wdata = {q_head_i.gy[GW-1:0], q_head_i.gx[GW-1:0]};
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_we   = pop_write & q_head_i.in_store;
        mem_addr = {YW'(q_head_i.pos_y), XW'(q_head_i.pos_x)};
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grad_store_q[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= grad_store_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      ev_x_q     <= '0;
      ev_y_q     <= '0;
      nb_ok_q    <= 1'b0;
    end else begin
      nb_ok_q <= (state_q == ST_READ) && nb_in_frame;
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (&clr_addr_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop_event) begin
            ev_x_q  <= q_head_i.pos_x;
            ev_y_q  <= q_head_i.pos_y;
            col_q   <= '0;
            row_q   <= '0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (col_q == 2'd2) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
            if (row_q == 2'd2) begin
              state_q <= ST_DRAIN;
            end
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_HAND;
        end
        ST_HAND: begin
          if (sum_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign gx  = rdata_q[GW-1:0];
  assign gy  = rdata_q[2*GW-1:GW];
  assign pxx = gx * gx;
  assign pyy = gy * gy;
  assign pxy = gx * gy;

  always_ff @(posedge clk_i) begin
    if (pop_event) begin
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
    end else if (nb_ok_q) begin
      sxx_q <= sxx_q + SW'($unsigned(pxx));
      syy_q <= syy_q + SW'($unsigned(pyy));
      sxy_q <= sxy_q + (SW + 1)'(pxy);
    end
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign sum_valid_o = (state_q == ST_HAND);
  assign sxx_o       = sxx_q;
  assign syy_o       = syy_q;
  assign sxy_o       = sxy_q;
  assign ev_x_o      = ev_x_q;
  assign ev_y_o      = ev_y_q;

endmodule

// ===== sv/hcr_resp.sv =====
`timescale 1ns / 1ps

module hcr_resp #(
  parameter int unsigned GRAD_BITS = hcr_pkg::GRAD_BITS_DEFAULT,
  localparam int unsigned SW       = 2 * GRAD_BITS + 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [hcr_pkg::K_W-1:0]            harris_k_i,
  input  logic                               sum_valid_i,
  output logic                               sum_ready_o,
  input  logic [SW-1:0]                      sxx_i,
  input  logic [SW-1:0]                      syy_i,
  input  logic signed [SW:0]                 sxy_i,
  input  logic [hcr_pkg::POS_W-1:0]          ev_x_i,
  input  logic [hcr_pkg::POS_W-1:0]          ev_y_i,
  output logic                               resp_valid_o,
  output logic signed [hcr_pkg::RESP_W-1:0]  response_o,
  output logic [hcr_pkg::POS_W-1:0]          out_x_o,
  output logic [hcr_pkg::POS_W-1:0]          out_y_o
);
  import hcr_pkg::*;

  localparam int unsigned MW  = (SW + 1 > K_W) ? SW + 1 : K_W;
  localparam int unsigned KTW = 2 * MW + K_W;
  localparam int unsigned DW  = 2 * MW + 2;
  localparam int unsigned EW  = ((DW > RESP_W) ? DW : RESP_W) + 1;
  localparam logic signed [EW-1:0] SatHi = {{(EW - RESP_W + 1){1'b0}}, {(RESP_W - 1){1'b1}}};
  localparam logic signed [EW-1:0] SatLo = {{(EW - RESP_W + 1){1'b1}}, {(RESP_W - 1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_P1,
    S_P2,
    S_T2,
    S_KLO,
    S_KHI,
    S_KSUM,
    S_DIFF,
    S_SAT
  } state_e;

  state_e                    state_q;
  logic                      resp_valid_q;
  logic signed [RESP_W-1:0]  response_q;
  logic [POS_W-1:0]          out_x_q;
  logic [POS_W-1:0]          out_y_q;

  logic [POS_W-1:0]      x_q;
  logic [POS_W-1:0]      y_q;
  logic [MW-1:0]         sxx_q;
  logic [MW-1:0]         syy_q;
  logic [MW-1:0]         sxym_q;
  logic [MW-1:0]         trace_q;
  logic [MW-1:0]         t2hi_q;
  logic [2*MW-1:0]       prod_q;
  logic signed [2*MW:0]  det_q;
  logic [KTW-1:0]        kt_q;
  logic signed [DW-1:0]  diff_q;

  logic                  take;
  logic signed [SW:0]    sxy_neg;
  logic [SW-1:0]         sxy_mag;
  logic [MW-1:0]         mul_a;
  logic [MW-1:0]         mul_b;
  logic [2*MW-1:0]       prod_d;
  logic signed [EW-1:0]  diff_ext;
  logic signed [RESP_W-1:0] sat_val;

  assign sum_ready_o = (state_q == S_IDLE);
  assign take        = sum_ready_o & sum_valid_i;
  assign sxy_neg     = -sxy_i;
  assign sxy_mag     = sxy_i[SW] ? sxy_neg[SW-1:0] : sxy_i[SW-1:0];

  // one shared multiplier, stepped through the products
  always_comb begin
    mul_a = sxx_q;
    mul_b = syy_q;
    case (state_q)
      S_P2: begin
        mul_a = sxym_q;
        mul_b = sxym_q;
      end
      S_T2: begin
        mul_a = trace_q;
        mul_b = trace_q;
      end
      S_KLO: begin
        mul_a = prod_q[MW-1:0];
        mul_b = MW'(harris_k_i);
      end
      S_KHI: begin
        mul_a = t2hi_q;
        mul_b = MW'(harris_k_i);
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          sxx_q   <= MW'(sxx_i);
          syy_q   <= MW'(syy_i);
          sxym_q  <= MW'(sxy_mag);
          trace_q <= MW'({1'b0, sxx_i} + {1'b0, syy_i});
          x_q     <= ev_x_i;
          y_q     <= ev_y_i;
        end
      end
      S_P2:   det_q  <= $signed({1'b0, prod_q});
      S_T2:   det_q  <= det_q - $signed({1'b0, prod_q});
      S_KLO:  t2hi_q <= prod_q[2*MW-1:MW];
      S_KHI:  kt_q   <= KTW'(prod_q);
      S_KSUM: kt_q   <= kt_q + (KTW'(prod_q) << MW);
      S_DIFF: diff_q <= DW'(det_q) - $signed({2'b00, kt_q[KTW-1:K_W]});
      default: ;
    endcase
  end

  always_comb begin
    diff_ext = EW'(diff_q);
    if (diff_ext > SatHi) begin
      sat_val = SatHi[RESP_W-1:0];
    end else if (diff_ext < SatLo) begin
      sat_val = SatLo[RESP_W-1:0];
    end else begin
      sat_val = diff_ext[RESP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      resp_valid_q <= 1'b0;
      response_q   <= '0;
      out_x_q      <= '0;
      out_y_q      <= '0;
    end else begin
      resp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            state_q <= S_P1;
          end
        end
        S_P1:   state_q <= S_P2;
        S_P2:   state_q <= S_T2;
        S_T2:   state_q <= S_KLO;
        S_KLO:  state_q <= S_KHI;
        S_KHI:  state_q <= S_KSUM;
        S_KSUM: state_q <= S_DIFF;
        S_DIFF: state_q <= S_SAT;
        S_SAT: begin
          resp_valid_q <= 1'b1;
          response_q   <= sat_val;
          out_x_q      <= x_q;
          out_y_q      <= y_q;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign resp_valid_o = resp_valid_q;
  assign response_o   = response_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;

endmodule
